// File: sv/mqcf_pkg.sv
// Package for the multi-queue character FIFO: sizing constants, command codes,
// and the command and result beat types.
// No dependencies.
package mqcf_pkg;

    localparam int NUM_QUEUES  = 8;
    localparam int QUEUE_DEPTH = 16;

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = (NUM_QUEUES * QUEUE_DEPTH > 2) ? $clog2(NUM_QUEUES * QUEUE_DEPTH) : 1;
    localparam int MEM_WORDS = NUM_QUEUES * QUEUE_DEPTH;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_DEL = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [QW-1:0] t_qsel;
    typedef logic [PW-1:0] t_ptr;
    typedef logic [FW-1:0] t_fill;
    typedef logic [AW-1:0] t_addr;

    typedef struct packed {
        logic       req_type;
        logic [2:0] queue_index;
        logic [7:0] data_in;
    } t_cmd;

    typedef struct packed {
        logic [7:0] data_out;
        logic [1:0] status;
        logic [4:0] fill_after;
    } t_rsp;

endpackage

// File: sv/multi_queue_char_fifo.sv
// Multi-queue character FIFO: one command beat per cycle unless the output stalls.
// Each result is registered in stage 2 and then in the output register; an output stall
// holds stage 2 and raises o_in_stall.
// Head and fill per queue update at accept, so back-to-back same-queue commands see them.
// Reset (i_rst_n low, synchronous) empties every queue; storage contents are kept.
// Depends on mqcf_pkg.
module multi_queue_char_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mqcf_pkg::t_cmd i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mqcf_pkg::t_rsp o_out
);
    import mqcf_pkg::*;

    logic [7:0] r_mem [MEM_WORDS];
    t_ptr       r_head [NUM_QUEUES];
    t_fill      r_fill [NUM_QUEUES];

    logic       r_s2_valid, n_s2_valid;
    logic       r_s2_del_ok;
    logic [1:0] r_s2_status;
    logic [4:0] r_s2_fill;
    logic [7:0] r_rd_data;

    logic       r_out_valid, n_out_valid;
    t_rsp       r_out;

    logic       acc, out_free, s2_move;
    logic       q_ok, is_del, full, empty, add_ok, del_ok;
    t_qsel      q;
    t_ptr       h, tail, head_inc;
    t_fill      n, fill_new;
    logic [PW:0] sum;
    t_addr      base, wr_addr, rd_addr;
    logic [1:0] status;

    always_comb begin
        q        = QW'(i_in.queue_index);
        q_ok     = (32'(i_in.queue_index) < NUM_QUEUES);
        h        = r_head[q];
        n        = r_fill[q];
        is_del   = (i_in.req_type == REQ_DEL);
        full     = (n >= FW'(QUEUE_DEPTH));
        empty    = (n == '0);
        add_ok   = q_ok & ~is_del & ~full;
        del_ok   = q_ok & is_del & ~empty;
        sum      = (PW+1)'(h) + (PW+1)'(n);
        tail     = (sum >= (PW+1)'(QUEUE_DEPTH)) ? PW'(sum - (PW+1)'(QUEUE_DEPTH)) : PW'(sum);
        head_inc = (h == PW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
        base     = AW'(q) * AW'(QUEUE_DEPTH);
        wr_addr  = base + AW'(tail);
        rd_addr  = base + AW'(h);
        if (add_ok) begin
            fill_new = n + 1'b1;
        end else if (del_ok) begin
            fill_new = n - 1'b1;
        end else begin
            fill_new = n;
        end
        if (!q_ok) begin
            status = ST_OK;
        end else if (is_del && empty) begin
            status = ST_EMPTY;
        end else if (!is_del && full) begin
            status = ST_FULL;
        end else begin
            status = ST_OK;
        end
    end

    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign s2_move    = r_s2_valid & out_free;
    assign o_in_stall = r_s2_valid & ~out_free;
    assign acc        = i_in_valid & ~o_in_stall;

    always_comb begin
        n_s2_valid = r_s2_valid;
        if (acc) begin
            n_s2_valid = 1'b1;
        end else if (s2_move) begin
            n_s2_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s2_move) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // storage: write tail on add, read head on delete
    always_ff @(posedge i_clk) begin
        if (acc && add_ok) begin
            r_mem[wr_addr] <= i_in.data_in;
        end
        if (acc && del_ok) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
        end else if (acc && q_ok) begin
            r_fill[q] <= fill_new;
            if (del_ok) begin
                r_head[q] <= head_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s2_valid  <= n_s2_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s2_del_ok <= del_ok;
            r_s2_status <= status;
            r_s2_fill   <= q_ok ? 5'(fill_new) : 5'd0;
        end
        if (s2_move) begin
            r_out.data_out   <= r_s2_del_ok ? r_rd_data : 8'd0;
            r_out.status     <= r_s2_status;
            r_out.fill_after <= r_s2_fill;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_acc_fills_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_s2_valid)
        else $error("accepted command did not reach stage 2");

    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !s2_move |=> r_s2_valid)
        else $error("stalled stage 2 beat lost");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && q_ok |-> r_fill[q] <= FW'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_empty_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_EMPTY |-> o_out.fill_after == 5'd0 &&
        o_out.data_out == 8'd0)
        else $error("empty delete result not zero");

    a_full_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_FULL |-> o_out.fill_after == 5'(QUEUE_DEPTH))
        else $error("full add result not at depth");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for multi_queue_char_fifo: random commands against a ring-queue predictor.
// Depends on mqcf_pkg and multi_queue_char_fifo.
module tb;
    import mqcf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1750;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic rsp_stall = 1'b0;
    t_cmd cmd_beat = '0;
    logic in_stall;
    logic rsp_valid;
    t_rsp rsp_beat;

    t_cmd pending_cmds[$];
    t_rsp expected_rsp[$];
    logic cmd_taken = 1'b0;

    logic [7:0] ring_mem [NUM_QUEUES*QUEUE_DEPTH];
    int ring_head [NUM_QUEUES];
    int ring_fill [NUM_QUEUES];

    int cycle_count = 0;
    int cmd_queued = 0;
    int cmd_accepted = 0;
    int rsp_seen = 0;
    int fail_count = 0;
    int add_count = 0;
    int del_count = 0;
    int full_hits = 0;
    int empty_hits = 0;
    int pauses = 0;

    multi_queue_char_fifo u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (cmd_valid),
        .o_in_stall  (in_stall),
        .i_in        (cmd_beat),
        .o_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .o_out       (rsp_beat)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_rsp apply_queue_command(t_cmd c);
        t_rsp r;
        int q;
        int h;
        int n;
        r = '0;
        q = c.queue_index;
        if (q < NUM_QUEUES) begin
            h = ring_head[q];
            n = ring_fill[q];
            if (c.req_type == REQ_ADD) begin
                add_count++;
                if (n >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                    full_hits++;
                end else begin
                    ring_mem[q*QUEUE_DEPTH + (h + n) % QUEUE_DEPTH] = c.data_in;
                    n++;
                    ring_fill[q] = n;
                end
            end else begin
                del_count++;
                if (n == 0) begin
                    r.status = ST_EMPTY;
                    empty_hits++;
                end else begin
                    r.data_out = ring_mem[q*QUEUE_DEPTH + h];
                    ring_head[q] = (h + 1) % QUEUE_DEPTH;
                    n--;
                    ring_fill[q] = n;
                end
            end
            r.fill_after = n[4:0];
        end
        return r;
    endfunction

    function automatic logic steady_stretch();
        return cmd_accepted >= 700 && cmd_accepted < 1000;
    endfunction

    // driver: hold a stalled beat, otherwise advance or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_valid <= 1'b0;
            rsp_stall <= 1'b0;
        end else begin
            if (!cmd_valid || cmd_taken) begin
                if (pending_cmds.size() != 0
                        && (steady_stretch() || $urandom_range(0, 99) >= 22)) begin
                    cmd_valid <= 1'b1;
                    cmd_beat  <= pending_cmds.pop_front();
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
            rsp_stall <= !steady_stretch() && ($urandom_range(0, 99) < 22);
        end
    end

    // monitor: predict on each command beat, check each result beat
    always @(posedge i_clk) begin
        cmd_taken <= i_rst_n && cmd_valid && !in_stall;
        if (i_rst_n) begin
            if (cmd_valid && !in_stall) begin
                expected_rsp.push_back(apply_queue_command(cmd_beat));
                cmd_accepted++;
            end
            if (rsp_valid && !rsp_stall) begin
                rsp_seen++;
                if (expected_rsp.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat %0d: %p", rsp_seen, rsp_beat);
                end else if (rsp_beat !== expected_rsp[0]) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("result beat %0d mismatch: data_out exp %02h got %02h,",
                                 rsp_seen, expected_rsp[0].data_out, rsp_beat.data_out);
                        $display("  status exp %0d got %0d, fill_after exp %0d got %0d",
                                 expected_rsp[0].status, rsp_beat.status,
                                 expected_rsp[0].fill_after, rsp_beat.fill_after);
                    end
                    void'(expected_rsp.pop_front());
                end else begin
                    void'(expected_rsp.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_rsp.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_cmd(logic req, int q, int data);
        t_cmd c;
        c.req_type = req;
        c.queue_index = q[2:0];
        c.data_in = data[7:0];
        pending_cmds.push_back(c);
        cmd_queued++;
    endtask

    task automatic drain_all();
        while (cmd_accepted != cmd_queued || expected_rsp.size() != 0)
            @(negedge i_clk);
        pauses++;
    endtask

    initial begin
        int made;
        int chunk;
        int mode;
        int hot_q;
        int alt_q;
        int add_pct;
        int q;
        for (int i = 0; i < NUM_QUEUES; i++) begin
            ring_head[i] = 0;
            ring_fill[i] = 0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: delete from empty, fill one queue past full, queue index extremes
        push_cmd(REQ_DEL, 5, 8'hFF);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i == 0)
                push_cmd(REQ_ADD, 3, 8'h00);
            else if (i == 1)
                push_cmd(REQ_ADD, 3, 8'hFF);
            else if (i < 10)
                push_cmd(REQ_ADD, 3, 8'h01 << (i - 2));
            else
                push_cmd(REQ_ADD, 3, $urandom_range(0, 255));
        end
        push_cmd(REQ_ADD, 3, 8'h5A);
        push_cmd(REQ_DEL, 3, 8'h00);
        push_cmd(REQ_ADD, 0, 8'hFF);
        push_cmd(REQ_DEL, 0, 8'h00);
        push_cmd(REQ_DEL, 0, 8'hA5);
        push_cmd(REQ_ADD, 7, 8'h00);
        push_cmd(REQ_DEL, 7, 8'hFF);
        drain_all();

        // random: phases biased to fill or drain a few queues, plus spread traffic
        made = 0;
        chunk = 0;
        while (made < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 3);
            hot_q = $urandom_range(0, NUM_QUEUES - 1);
            alt_q = $urandom_range(0, NUM_QUEUES - 1);
            case (mode)
                0: add_pct = 80;
                1: add_pct = 25;
                2: add_pct = 50;
                default: add_pct = 60;
            endcase
            for (int n = $urandom_range(20, 60); n > 0; n--) begin
                if (mode == 2)
                    q = $urandom_range(0, NUM_QUEUES - 1);
                else if (mode == 3)
                    q = $urandom_range(0, 1) ? hot_q : alt_q;
                else
                    q = hot_q;
                push_cmd(($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_DEL, q,
                         $urandom_range(0, 255));
                made++;
            end
            chunk++;
            if (chunk % 6 == 0)
                drain_all();
            else
                while (pending_cmds.size() > 8)
                    @(negedge i_clk);
        end

        while (cmd_accepted != cmd_queued || expected_rsp.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (expected_rsp.size() != 0)
            fail_count++;

        $display("covered %0d commands (%0d adds, %0d deletes), %0d full-queue adds, %0d",
                 cmd_accepted, add_count, del_count, full_hits, empty_hits);
        $display("  empty-queue deletes, %0d drain pauses, %0d result beats checked",
                 pauses, rsp_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
